### rtl/mdt_pkg.sv
// Shared constants, types and codes of the multi-slot deadline timer.
package mdt_pkg;

    localparam int SLOT_COUNT       = 4;
    localparam int INTERRUPT_LIMIT  = 1020;
    localparam int FIRST_ARMABLE_ID = 32;
    localparam int MS_PER_SECOND    = 1000;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ID_W       = 10;
    localparam int OWNER_W    = 8;
    localparam int TIME_W     = 64;
    localparam int FREQ_W     = 32;
    localparam int MS_W       = 32;
    localparam int VALID_W    = 4;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 3;
    localparam int REM_W      = $clog2(MS_PER_SECOND);
    localparam int VALID_EXT_W = (SLOT_COUNT > VALID_W) ? SLOT_COUNT : VALID_W;

    // The divide by 1000 walks the dividend in 16-bit digits; each digit step uses a
    // reciprocal multiply that is exact for partial values below 1000 * 2^16.
    localparam int DIV_DIGIT_W = 16;
    localparam int DIV_STEPS   = TIME_W / DIV_DIGIT_W;
    localparam int DIV_VAL_W   = REM_W + DIV_DIGIT_W;
    localparam int DIV_RECIP   = 274877907;
    localparam int DIV_RECIP_W = 29;
    localparam int DIV_SHIFT   = 38;
    localparam int DIV_PROD_W  = DIV_VAL_W + DIV_RECIP_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // Input word layout, lowest bit first.
    localparam int IN_NOW_LSB   = 0;
    localparam int IN_ID_LSB    = IN_NOW_LSB + TIME_W;
    localparam int IN_MS_LSB    = IN_ID_LSB + ID_W;
    localparam int IN_OWNER_LSB = IN_MS_LSB + MS_W;
    localparam int IN_PERM_BIT  = IN_OWNER_LSB + OWNER_W;
    localparam int IN_RUN_BIT   = IN_PERM_BIT + 1;
    localparam int IN_VALID_LSB = IN_RUN_BIT + 1;
    localparam int IN_DATA_W    = ((IN_VALID_LSB + VALID_W + 7) / 8) * 8;

    // Output word layout.
    localparam int OUT_DATA_W = ((ID_W + 1 + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_IDX_FREQ = 1'b0;
    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_ARM  = 2'd0,
        OP_STOP = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ARM_OK     = 3'd0,
        KIND_ARM_REJECT = 3'd1,
        KIND_STOP_DONE  = 3'd2,
        KIND_PENDING    = 3'd3,
        KIND_TICK_DONE  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [ID_W-1:0]    intid;
        logic [OWNER_W-1:0] owner;
        logic [TIME_W-1:0]  deadline;
    } slot_entry_t;

endpackage

### rtl/mdt_ms_to_ticks.sv
// Millisecond to counter tick converter: one multiply, then a divide by 1000 in 16-bit digits.
module mdt_ms_to_ticks (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mdt_pkg::FREQ_W-1:0]  freq,
    input  logic [mdt_pkg::MS_W-1:0]    ms,
    output logic                        busy,
    output logic [mdt_pkg::TIME_W-1:0]  ticks
);

    logic                              busy_reg;
    logic [mdt_pkg::STEP_W-1:0]        cnt_reg;
    logic [mdt_pkg::TIME_W-1:0]        quo_reg;
    logic [mdt_pkg::REM_W-1:0]         rem_reg;
    logic [mdt_pkg::TIME_W-1:0]        product;
    logic [mdt_pkg::DIV_VAL_W-1:0]     part;
    logic [mdt_pkg::DIV_PROD_W-1:0]    recip_prod;
    logic [mdt_pkg::DIV_DIGIT_W-1:0]   q_digit;
    logic [mdt_pkg::DIV_VAL_W-1:0]     q_times;
    logic [mdt_pkg::REM_W-1:0]         rem_next;

    assign product = mdt_pkg::TIME_W'(freq) * mdt_pkg::TIME_W'(ms);

    // One digit per cycle: the dividend digits shift out of the top of the quotient
    // register while quotient digits shift in at the bottom. The partial value is the
    // running remainder followed by the next digit, so it stays below 1000 * 2^16.
    assign part       = {rem_reg, quo_reg[mdt_pkg::TIME_W-1 -: mdt_pkg::DIV_DIGIT_W]};
    assign recip_prod = mdt_pkg::DIV_PROD_W'(part)
                        * mdt_pkg::DIV_PROD_W'(mdt_pkg::DIV_RECIP);
    assign q_digit    = recip_prod[mdt_pkg::DIV_SHIFT +: mdt_pkg::DIV_DIGIT_W];
    assign q_times    = mdt_pkg::DIV_VAL_W'(q_digit)
                        * mdt_pkg::DIV_VAL_W'(mdt_pkg::MS_PER_SECOND);
    assign rem_next   = mdt_pkg::REM_W'(part - q_times);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == mdt_pkg::STEP_W'(mdt_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= product;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[mdt_pkg::TIME_W-mdt_pkg::DIV_DIGIT_W-1:0], q_digit};
            rem_reg <= rem_next;
        end
    end

    assign busy  = busy_reg;
    assign ticks = quo_reg;

endmodule

### rtl/mdt_slot_table.sv
// Timer slot table: interrupt id, owner and deadline per slot, one read port, one write port and one id clear port.
module mdt_slot_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [mdt_pkg::SLOT_IDX_W-1:0]  rd_idx,
    output mdt_pkg::slot_entry_t            rd_entry,
    input  logic                            wr_en,
    input  logic [mdt_pkg::SLOT_IDX_W-1:0]  wr_idx,
    input  mdt_pkg::slot_entry_t            wr_entry,
    input  logic                            clr_en,
    input  logic [mdt_pkg::SLOT_IDX_W-1:0]  clr_idx
);

    logic [mdt_pkg::ID_W-1:0]    id_reg       [mdt_pkg::SLOT_COUNT];
    logic [mdt_pkg::OWNER_W-1:0] owner_reg    [mdt_pkg::SLOT_COUNT];
    logic [mdt_pkg::TIME_W-1:0]  deadline_reg [mdt_pkg::SLOT_COUNT];

    // An id of zero marks a free slot, so only the ids need a reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mdt_pkg::SLOT_COUNT; i++)
            begin
                id_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            id_reg[wr_idx] <= wr_entry.intid;
        end
        else if (clr_en)
        begin
            id_reg[clr_idx] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_reg[wr_idx]    <= wr_entry.owner;
            deadline_reg[wr_idx] <= wr_entry.deadline;
        end
    end

    assign rd_entry.intid    = id_reg[rd_idx];
    assign rd_entry.owner    = owner_reg[rd_idx];
    assign rd_entry.deadline = deadline_reg[rd_idx];

endmodule

### rtl/multi_slot_deadline_timer.sv
// Top level of the multi-slot deadline timer: sequencer, output register and register port.
//
// The block keeps SLOT_COUNT timer slots and handles one word at a time; s_tready is low
// while a word is in work. A stop, a tick and an arm scan the slots, and an arm that finds
// the table full then goes to the result. The sequencer visits one slot per cycle, unless
// a tick holds a due slot until the output register is free, through a single table read
// port and a single 64-bit deadline comparator. A tick waits for the output register to
// drain before each pending-interrupt word, and every request before its final word. An
// accepted arm runs the slot scan, loads the frequency times milliseconds product, runs
// four digit steps of the divide by 1000 on one reciprocal multiplier, then sees the
// converter done, writes the slot and gives the result. An arm rejected at the input, or
// an unknown request, goes straight from idle to the result. counter_frequency sits at
// byte address 0 and resets to 1.
module multi_slot_deadline_timer (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input word.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata from bit 0: now, intid, delay_ms, owner_tag, arm_permitted,
    // partition_running, owner_still_valid.
    input  logic [mdt_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser: operation.
    input  logic [mdt_pkg::OP_W-1:0]          s_tuser,
    // Result word.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata from bit 0: pending_intid, timer_rearm, zero padding.
    output logic [mdt_pkg::OUT_DATA_W-1:0]    m_tdata,
    // tuser: kind.
    output logic [mdt_pkg::KIND_W-1:0]        m_tuser,
    output logic                              m_tlast,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mdt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [mdt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [mdt_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_ARM_SCAN  = 7'b0000010,
        ST_ARM_CALC  = 7'b0000100,
        ST_ARM_WRITE = 7'b0001000,
        ST_STOP_SCAN = 7'b0010000,
        ST_TICK_SCAN = 7'b0100000,
        ST_RESP      = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [mdt_pkg::FREQ_W-1:0]      freq_reg;
    logic [mdt_pkg::SLOT_IDX_W-1:0]  idx_reg, idx_next;
    logic                            match_found_reg, match_found_next;
    logic [mdt_pkg::SLOT_IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic                            free_found_reg, free_found_next;
    logic [mdt_pkg::SLOT_IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [mdt_pkg::SLOT_IDX_W-1:0]  pick_reg, pick_next;
    logic                            armed_reg, armed_next;
    mdt_pkg::kind_t                  resp_kind_reg, resp_kind_next;
    logic                            resp_rearm_reg, resp_rearm_next;

    // Fields of the word in work.
    logic [mdt_pkg::TIME_W-1:0]      now_reg;
    logic [mdt_pkg::ID_W-1:0]        intid_reg;
    logic [mdt_pkg::MS_W-1:0]        ms_reg;
    logic [mdt_pkg::OWNER_W-1:0]     owner_reg;
    logic                            running_reg;
    logic [mdt_pkg::VALID_W-1:0]     valid_reg;

    // Output register.
    logic                            out_valid_reg;
    mdt_pkg::kind_t                  out_kind_reg;
    logic [mdt_pkg::ID_W-1:0]        out_id_reg;
    logic                            out_rearm_reg;
    logic                            out_last_reg;
    logic                            out_free;
    logic                            out_load;
    mdt_pkg::kind_t                  load_kind;
    logic [mdt_pkg::ID_W-1:0]        load_id;
    logic                            load_rearm;
    logic                            load_last;

    logic                            in_accept;
    mdt_pkg::op_t                    in_op;
    logic [mdt_pkg::ID_W-1:0]        in_intid;
    logic                            in_reject;
    logic                            cfg_write;

    mdt_pkg::slot_entry_t            rd_entry;
    mdt_pkg::slot_entry_t            wr_entry;
    logic                            wr_en;
    logic                            clr_en;
    logic                            calc_start;
    logic                            calc_busy;
    logic [mdt_pkg::TIME_W-1:0]      calc_ticks;

    logic                            idx_last;
    logic [mdt_pkg::SLOT_IDX_W-1:0]  idx_inc;
    logic                            hit;
    logic                            slot_free;
    logic                            m_found;
    logic                            f_found;
    logic [mdt_pkg::SLOT_IDX_W-1:0]  m_idx;
    logic [mdt_pkg::SLOT_IDX_W-1:0]  f_idx;
    logic [mdt_pkg::VALID_EXT_W-1:0] valid_wide;
    logic [mdt_pkg::SLOT_COUNT-1:0]  valid_ext;
    logic                            partition_slot;
    logic                            dropped;
    logic                            reached;
    logic                            due;
    logic                            keep;
    logic                            advance;

    mdt_slot_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_idx   (pick_reg),
        .wr_entry (wr_entry),
        .clr_en   (clr_en),
        .clr_idx  (idx_reg)
    );

    mdt_ms_to_ticks u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .freq  (freq_reg),
        .ms    (ms_reg),
        .busy  (calc_busy),
        .ticks (calc_ticks)
    );

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[mdt_pkg::CFG_ADDR_W-1] == mdt_pkg::REG_IDX_FREQ);
    assign prdata    = (paddr[mdt_pkg::CFG_ADDR_W-1] == mdt_pkg::REG_IDX_FREQ)
                       ? mdt_pkg::CFG_DATA_W'(freq_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= mdt_pkg::FREQ_RESET;
        end
        else if (cfg_write)
        begin
            freq_reg <= pwdata[mdt_pkg::FREQ_W-1:0];
        end
    end

    // Input side.
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_op     = mdt_pkg::op_t'(s_tuser);
    assign in_intid  = s_tdata[mdt_pkg::IN_ID_LSB +: mdt_pkg::ID_W];
    assign in_reject = !s_tdata[mdt_pkg::IN_PERM_BIT]
                       || ({1'b0, in_intid} < (mdt_pkg::ID_W + 1)'(mdt_pkg::FIRST_ARMABLE_ID))
                       || ({1'b0, in_intid} >= (mdt_pkg::ID_W + 1)'(mdt_pkg::INTERRUPT_LIMIT));

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg     <= s_tdata[mdt_pkg::IN_NOW_LSB +: mdt_pkg::TIME_W];
            intid_reg   <= in_intid;
            ms_reg      <= s_tdata[mdt_pkg::IN_MS_LSB +: mdt_pkg::MS_W];
            owner_reg   <= s_tdata[mdt_pkg::IN_OWNER_LSB +: mdt_pkg::OWNER_W];
            running_reg <= s_tdata[mdt_pkg::IN_RUN_BIT];
            valid_reg   <= s_tdata[mdt_pkg::IN_VALID_LSB +: mdt_pkg::VALID_W];
        end
    end

    // Slot walk helpers.
    assign idx_last = (idx_reg == mdt_pkg::SLOT_IDX_W'(mdt_pkg::SLOT_COUNT - 1));
    assign idx_inc  = idx_reg + 1'b1;

    assign hit       = (rd_entry.intid == intid_reg);
    assign slot_free = (rd_entry.intid == '0);
    assign m_found   = match_found_reg || hit;
    assign m_idx     = hit ? idx_reg : match_idx_reg;
    assign f_found   = free_found_reg || slot_free;
    assign f_idx     = free_found_reg ? free_idx_reg : idx_reg;

    // Slots past the four validity bits read as no longer owned.
    assign valid_wide     = mdt_pkg::VALID_EXT_W'(valid_reg);
    assign valid_ext      = valid_wide[mdt_pkg::SLOT_COUNT-1:0];
    assign partition_slot = (rd_entry.owner != '0);
    assign dropped        = partition_slot && !valid_ext[idx_reg];
    assign reached        = (now_reg >= rd_entry.deadline);
    assign due            = !slot_free && !dropped && reached
                            && (partition_slot || running_reg);
    assign keep           = !slot_free && !dropped && !due;

    assign wr_entry.intid    = intid_reg;
    assign wr_entry.owner    = owner_reg;
    assign wr_entry.deadline = now_reg + calc_ticks;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        pick_next        = pick_reg;
        armed_next       = armed_reg;
        resp_kind_next   = resp_kind_reg;
        resp_rearm_next  = resp_rearm_reg;
        calc_start       = 1'b0;
        wr_en            = 1'b0;
        clr_en           = 1'b0;
        out_load         = 1'b0;
        load_kind        = mdt_pkg::KIND_PENDING;
        load_id          = '0;
        load_rearm       = 1'b0;
        load_last        = 1'b0;
        advance          = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    armed_next       = 1'b0;
                    unique case (in_op)
                        mdt_pkg::OP_ARM:
                        begin
                            if (in_reject)
                            begin
                                resp_kind_next  = mdt_pkg::KIND_ARM_REJECT;
                                resp_rearm_next = 1'b0;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_ARM_SCAN;
                            end
                        end
                        mdt_pkg::OP_STOP:
                        begin
                            state_next = ST_STOP_SCAN;
                        end
                        mdt_pkg::OP_TICK:
                        begin
                            state_next = ST_TICK_SCAN;
                        end
                        default:
                        begin
                            resp_kind_next  = mdt_pkg::KIND_TICK_DONE;
                            resp_rearm_next = 1'b0;
                            state_next      = ST_RESP;
                        end
                    endcase
                end
            end

            ST_ARM_SCAN:
            begin
                // The highest slot holding the id wins; else the lowest free one.
                match_found_next = m_found;
                match_idx_next   = m_idx;
                free_found_next  = f_found;
                free_idx_next    = f_idx;
                if (idx_last)
                begin
                    if (m_found || f_found)
                    begin
                        pick_next  = m_found ? m_idx : f_idx;
                        calc_start = 1'b1;
                        state_next = ST_ARM_CALC;
                    end
                    else
                    begin
                        resp_kind_next  = mdt_pkg::KIND_ARM_REJECT;
                        resp_rearm_next = 1'b0;
                        state_next      = ST_RESP;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            ST_ARM_CALC:
            begin
                if (!calc_busy)
                begin
                    state_next = ST_ARM_WRITE;
                end
            end

            ST_ARM_WRITE:
            begin
                wr_en           = 1'b1;
                resp_kind_next  = mdt_pkg::KIND_ARM_OK;
                resp_rearm_next = 1'b1;
                state_next      = ST_RESP;
            end

            ST_STOP_SCAN:
            begin
                clr_en = !slot_free && (rd_entry.owner == owner_reg);
                if (idx_last)
                begin
                    resp_kind_next  = mdt_pkg::KIND_STOP_DONE;
                    resp_rearm_next = 1'b0;
                    state_next      = ST_RESP;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            ST_TICK_SCAN:
            begin
                if (dropped && !slot_free)
                begin
                    clr_en = 1'b1;
                end
                else if (due)
                begin
                    // A due slot waits here until the output register can take it.
                    if (out_free)
                    begin
                        out_load  = 1'b1;
                        load_kind = mdt_pkg::KIND_PENDING;
                        load_id   = rd_entry.intid;
                        clr_en    = 1'b1;
                    end
                    else
                    begin
                        advance = 1'b0;
                    end
                end
                if (keep)
                begin
                    armed_next = 1'b1;
                end
                if (advance)
                begin
                    if (idx_last)
                    begin
                        resp_kind_next  = mdt_pkg::KIND_TICK_DONE;
                        resp_rearm_next = armed_reg || keep;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_kind  = resp_kind_reg;
                    load_rearm = resp_rearm_reg;
                    load_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            armed_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            armed_reg       <= armed_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg  <= match_idx_next;
        free_idx_reg   <= free_idx_next;
        pick_reg       <= pick_next;
        resp_kind_reg  <= resp_kind_next;
        resp_rearm_reg <= resp_rearm_next;
        if (out_load)
        begin
            out_kind_reg  <= load_kind;
            out_id_reg    <= load_id;
            out_rearm_reg <= load_rearm;
            out_last_reg  <= load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mdt_pkg::OUT_DATA_W'({out_rearm_reg, out_id_reg});
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_calc_only_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        calc_busy |-> (state_reg == ST_ARM_CALC))
        else $error("tick converter busy outside the arm calculation");

    a_write_id_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((wr_entry.intid >= mdt_pkg::ID_W'(mdt_pkg::FIRST_ARMABLE_ID))
                   && ({1'b0, wr_entry.intid}
                       < (mdt_pkg::ID_W + 1)'(mdt_pkg::INTERRUPT_LIMIT))))
        else $error("slot written with an id outside the armable range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start any work");
`endif

endmodule

### bench/tb_multi_slot_deadline_timer.sv
// Self-checking testbench of the multi-slot deadline timer: directed and random words, checked against a predictor.
module tb_multi_slot_deadline_timer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int PHASE_ITEMS    = 94;
    localparam int REPORT_LIMIT   = 10;
    localparam int LONG_HOLD      = 400;
    localparam logic [mdt_pkg::CFG_ADDR_W-1:0] FREQ_ADDR =
        mdt_pkg::CFG_ADDR_W'(4 * mdt_pkg::REG_IDX_FREQ);

    typedef struct {
        mdt_pkg::op_t                op;
        logic [mdt_pkg::TIME_W-1:0]  now;
        logic [mdt_pkg::ID_W-1:0]    intid;
        logic [mdt_pkg::MS_W-1:0]    delay_ms;
        logic [mdt_pkg::OWNER_W-1:0] owner;
        logic                        permitted;
        logic                        running;
        logic [mdt_pkg::VALID_W-1:0] still_valid;
    } timer_item_t;

    typedef struct {
        mdt_pkg::kind_t           kind;
        logic [mdt_pkg::ID_W-1:0] intid;
        logic                     rearm;
        logic                     last;
    } timer_result_t;

    class timer_scoreboard;
        logic [mdt_pkg::FREQ_W-1:0]  freq;
        logic [mdt_pkg::ID_W-1:0]    slot_id [mdt_pkg::SLOT_COUNT];
        logic [mdt_pkg::TIME_W-1:0]  slot_due [mdt_pkg::SLOT_COUNT];
        logic [mdt_pkg::OWNER_W-1:0] slot_tag [mdt_pkg::SLOT_COUNT];
        timer_result_t               awaited [$];
        int                          mismatches;

        function new();
            freq = mdt_pkg::FREQ_RESET;
            mismatches = 0;
            for (int i = 0; i < mdt_pkg::SLOT_COUNT; i++)
            begin
                slot_id[i]  = '0;
                slot_due[i] = '0;
                slot_tag[i] = '0;
            end
        endfunction

        function void set_frequency(logic [mdt_pkg::FREQ_W-1:0] value);
            freq = value;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void push(mdt_pkg::kind_t kind, logic [mdt_pkg::ID_W-1:0] intid, logic rearm,
                           logic last);
            timer_result_t r;
            r.kind  = kind;
            r.intid = intid;
            r.rearm = rearm;
            r.last  = last;
            awaited.push_back(r);
        endfunction

        function void note_input(timer_item_t it);
            int pick;
            bit armed;
            bit due;
            bit still;
            logic [mdt_pkg::TIME_W-1:0] span;
            case (it.op)
                mdt_pkg::OP_ARM:
                begin
                    if (!it.permitted || it.intid < mdt_pkg::FIRST_ARMABLE_ID
                        || it.intid >= mdt_pkg::INTERRUPT_LIMIT)
                    begin
                        push(mdt_pkg::KIND_ARM_REJECT, '0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        pick = -1;
                        for (int i = 0; i < mdt_pkg::SLOT_COUNT; i++)
                            if (slot_id[i] == it.intid)
                                pick = i;
                        for (int i = 0; i < mdt_pkg::SLOT_COUNT && pick < 0; i++)
                            if (slot_id[i] == '0)
                                pick = i;
                        if (pick < 0)
                        begin
                            push(mdt_pkg::KIND_ARM_REJECT, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            span = (mdt_pkg::TIME_W'(freq) * mdt_pkg::TIME_W'(it.delay_ms))
                                   / mdt_pkg::TIME_W'(mdt_pkg::MS_PER_SECOND);
                            slot_due[pick] = it.now + span;
                            slot_id[pick]  = it.intid;
                            slot_tag[pick] = it.owner;
                            push(mdt_pkg::KIND_ARM_OK, '0, 1'b1, 1'b1);
                        end
                    end
                end
                mdt_pkg::OP_STOP:
                begin
                    for (int i = 0; i < mdt_pkg::SLOT_COUNT; i++)
                        if (slot_id[i] != '0 && slot_tag[i] == it.owner)
                            slot_id[i] = '0;
                    push(mdt_pkg::KIND_STOP_DONE, '0, 1'b0, 1'b1);
                end
                mdt_pkg::OP_TICK:
                begin
                    armed = 1'b0;
                    for (int i = 0; i < mdt_pkg::SLOT_COUNT; i++)
                    begin
                        if (slot_id[i] != '0)
                        begin
                            if (slot_tag[i] == '0)
                            begin
                                due = (it.now >= slot_due[i]) && it.running;
                            end
                            else
                            begin
                                still = (i < mdt_pkg::VALID_W)
                                        ? it.still_valid[i % mdt_pkg::VALID_W] : 1'b0;
                                due = (it.now >= slot_due[i]);
                            end
                            // A partition slot whose owner lost the interrupt is dropped silently.
                            if (slot_tag[i] != '0 && !still)
                            begin
                                slot_id[i] = '0;
                            end
                            else if (due)
                            begin
                                push(mdt_pkg::KIND_PENDING, slot_id[i], 1'b0, 1'b0);
                                slot_id[i] = '0;
                            end
                            else
                            begin
                                armed = 1'b1;
                            end
                        end
                    end
                    push(mdt_pkg::KIND_TICK_DONE, '0, armed, 1'b1);
                end
                default:
                    push(mdt_pkg::KIND_TICK_DONE, '0, 1'b0, 1'b1);
            endcase
        endfunction

        function void check_result(logic [mdt_pkg::KIND_W-1:0] kind,
                                   logic [mdt_pkg::ID_W-1:0] intid, logic rearm, logic last);
            timer_result_t exp_r;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: kind %0d intid %0d rearm %0b last %0b",
                             kind, intid, rearm, last);
                return;
            end
            exp_r = awaited.pop_front();
            if (kind !== exp_r.kind || intid !== exp_r.intid || rearm !== exp_r.rearm
                || last !== exp_r.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch exp/act: kind %0d/%0d id %0d/%0d rearm %0b/%0b last %0b/%0b",
                             exp_r.kind, kind, exp_r.intid, intid, exp_r.rearm, rearm,
                             exp_r.last, last);
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [mdt_pkg::IN_DATA_W-1:0]      s_tdata;
    logic [mdt_pkg::OP_W-1:0]           s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [mdt_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic [mdt_pkg::KIND_W-1:0]         m_tuser;
    logic                               m_tlast;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [mdt_pkg::CFG_ADDR_W-1:0]     paddr;
    logic [mdt_pkg::CFG_DATA_W-1:0]     pwdata;
    logic [mdt_pkg::CFG_DATA_W-1:0]     prdata;
    logic                               pready;

    timer_scoreboard sb = new();
    int              cycle_count = 0;
    int              tx_gap_max = 4;
    int              rx_gap_max = 4;
    int              rx_hold_cycles = 0;
    logic [mdt_pkg::TIME_W-1:0] clock_now = '0;

    multi_slot_deadline_timer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multi_slot_deadline_timer regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[mdt_pkg::ID_W-1:0], m_tdata[mdt_pkg::ID_W],
                            m_tlast);
    end

    // Result side: a random wait before each word, or a long hold-off when one is requested.
    initial
    begin
        int w;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                w = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                w = $urandom_range(0, rx_gap_max);
            end
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic send_word(timer_item_t it);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= mdt_pkg::IN_DATA_W'({it.still_valid, it.running, it.permitted, it.owner,
                                         it.delay_ms, it.intid, it.now});
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(it);
    endtask

    task automatic offer(mdt_pkg::op_t op, logic [mdt_pkg::TIME_W-1:0] now,
                         logic [mdt_pkg::ID_W-1:0] intid, logic [mdt_pkg::MS_W-1:0] ms,
                         logic [mdt_pkg::OWNER_W-1:0] owner, logic permitted,
                         logic running, logic [mdt_pkg::VALID_W-1:0] still_valid);
        timer_item_t it;
        it.op = op;
        it.now = now;
        it.intid = intid;
        it.delay_ms = ms;
        it.owner = owner;
        it.permitted = permitted;
        it.running = running;
        it.still_valid = still_valid;
        send_word(it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the frequency register, then reads it back.
    task automatic set_frequency(logic [mdt_pkg::FREQ_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FREQ_ADDR;
        pwdata  <= mdt_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_frequency(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[mdt_pkg::FREQ_W-1:0] !== value)
        begin
            sb.mismatches++;
            if (sb.mismatches <= REPORT_LIMIT)
                $display("register read mismatch: expected %0h actual %0h", value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [mdt_pkg::ID_W-1:0] pick_intid();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return mdt_pkg::ID_W'(mdt_pkg::FIRST_ARMABLE_ID + $urandom_range(0, 7));
        else if (r < 90)
            return mdt_pkg::ID_W'($urandom_range(0, 1023));
        case ($urandom_range(0, 5))
            0: return mdt_pkg::ID_W'(0);
            1: return mdt_pkg::ID_W'(mdt_pkg::FIRST_ARMABLE_ID - 1);
            2: return mdt_pkg::ID_W'(mdt_pkg::FIRST_ARMABLE_ID);
            3: return mdt_pkg::ID_W'(mdt_pkg::INTERRUPT_LIMIT - 1);
            4: return mdt_pkg::ID_W'(mdt_pkg::INTERRUPT_LIMIT);
            default: return '1;
        endcase
    endfunction

    function automatic logic [mdt_pkg::OWNER_W-1:0] pick_owner();
        if ($urandom_range(0, 99) < 85)
        begin
            case ($urandom_range(0, 4))
                0: return '0;
                1: return mdt_pkg::OWNER_W'(1);
                2: return mdt_pkg::OWNER_W'(2);
                3: return mdt_pkg::OWNER_W'(3);
                default: return '1;
            endcase
        end
        return mdt_pkg::OWNER_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random_word();
        timer_item_t it;
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            clock_now = {$urandom, $urandom};
        else
            clock_now = clock_now + mdt_pkg::TIME_W'($urandom_range(0, 2000));
        it.now         = clock_now;
        it.intid       = mdt_pkg::ID_W'($urandom_range(0, 1023));
        it.delay_ms    = $urandom;
        it.owner       = pick_owner();
        it.permitted   = ($urandom_range(0, 9) != 0);
        it.running     = ($urandom_range(0, 9) < 7);
        it.still_valid = ($urandom_range(0, 4) != 0) ? '1 : mdt_pkg::VALID_W'($urandom);
        if (r < 45)
        begin
            it.op    = mdt_pkg::OP_ARM;
            it.intid = pick_intid();
            if ($urandom_range(0, 9) < 7)
                it.delay_ms = mdt_pkg::MS_W'($urandom_range(0, 3000));
            if ($urandom_range(0, 9) == 0)
                it.now = {$urandom, $urandom};
        end
        else if (r < 60)
        begin
            it.op = mdt_pkg::OP_STOP;
        end
        else if (r < 97)
        begin
            it.op = mdt_pkg::OP_TICK;
            if ($urandom_range(0, 99) < 15)
                it.now = {$urandom, $urandom};
        end
        else
        begin
            it.op = mdt_pkg::OP_NONE;
        end
        send_word(it);
    endtask

    initial
    begin
        logic [mdt_pkg::FREQ_W-1:0] freq_plan [5];
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rejections: no permission, ids just outside the armable range, the top id.
        offer(mdt_pkg::OP_ARM, '0, mdt_pkg::ID_W'(40), mdt_pkg::MS_W'(5), '0, 1'b0, 1'b0, '0);
        offer(mdt_pkg::OP_ARM, '0, mdt_pkg::ID_W'(mdt_pkg::FIRST_ARMABLE_ID - 1),
              mdt_pkg::MS_W'(5), '0, 1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_ARM, '0, mdt_pkg::ID_W'(mdt_pkg::INTERRUPT_LIMIT),
              mdt_pkg::MS_W'(5), '0, 1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_ARM, '0, '1, mdt_pkg::MS_W'(5), '0, 1'b1, 1'b0, '0);
        // Fill the table, one deadline wrapping past the top of the counter.
        offer(mdt_pkg::OP_ARM, '0, mdt_pkg::ID_W'(mdt_pkg::FIRST_ARMABLE_ID), '0, '0,
              1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_ARM, '1, mdt_pkg::ID_W'(mdt_pkg::INTERRUPT_LIMIT - 1), '1, '1,
              1'b1, 1'b1, '1);
        offer(mdt_pkg::OP_ARM, mdt_pkg::TIME_W'(1000), mdt_pkg::ID_W'(100),
              mdt_pkg::MS_W'(2000), mdt_pkg::OWNER_W'(5), 1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_ARM, mdt_pkg::TIME_W'(1000), mdt_pkg::ID_W'(200),
              mdt_pkg::MS_W'(9000), mdt_pkg::OWNER_W'(5), 1'b1, 1'b0, '0);
        // Table full, then reuse of the slot that already holds id 100.
        offer(mdt_pkg::OP_ARM, mdt_pkg::TIME_W'(1000), mdt_pkg::ID_W'(300),
              mdt_pkg::MS_W'(1), mdt_pkg::OWNER_W'(6), 1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_ARM, mdt_pkg::TIME_W'(1000), mdt_pkg::ID_W'(100),
              mdt_pkg::MS_W'(0), mdt_pkg::OWNER_W'(7), 1'b1, 1'b0, '0);
        // Normal-world slot waits while no partition runs.
        offer(mdt_pkg::OP_TICK, mdt_pkg::TIME_W'(5000), '0, '0, '0, 1'b0, 1'b0, '1);
        // Owners lost their interrupts; the normal-world slot is now due.
        offer(mdt_pkg::OP_TICK, mdt_pkg::TIME_W'(5000), '0, '0, '0, 1'b0, 1'b1, '0);
        offer(mdt_pkg::OP_STOP, '0, '0, '0, mdt_pkg::OWNER_W'(9), 1'b0, 1'b0, '0);
        offer(mdt_pkg::OP_ARM, '0, mdt_pkg::ID_W'(33), mdt_pkg::MS_W'(50),
              mdt_pkg::OWNER_W'(4), 1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_ARM, '0, mdt_pkg::ID_W'(34), mdt_pkg::MS_W'(50),
              mdt_pkg::OWNER_W'(4), 1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_ARM, '0, mdt_pkg::ID_W'(35), mdt_pkg::MS_W'(50), '0,
              1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_STOP, '0, '0, '0, mdt_pkg::OWNER_W'(4), 1'b0, 1'b0, '0);
        offer(mdt_pkg::OP_NONE, '1, '1, '1, '1, 1'b1, 1'b1, '1);
        offer(mdt_pkg::OP_TICK, '1, '0, '0, '0, 1'b0, 1'b1, '1);
        offer(mdt_pkg::OP_TICK, '1, '0, '0, '0, 1'b0, 1'b1, '1);
        wait_drained();

        // Zero frequency: the deadline equals now.
        set_frequency('0);
        offer(mdt_pkg::OP_ARM, mdt_pkg::TIME_W'(777), mdt_pkg::ID_W'(500), '1,
              mdt_pkg::OWNER_W'(8), 1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_TICK, mdt_pkg::TIME_W'(777), '0, '0, '0, 1'b0, 1'b0, '1);
        wait_drained();
        set_frequency('1);
        offer(mdt_pkg::OP_ARM, '0, mdt_pkg::ID_W'(501), '1, mdt_pkg::OWNER_W'(8),
              1'b1, 1'b0, '0);
        offer(mdt_pkg::OP_TICK, '1, '0, '0, '0, 1'b0, 1'b0, '1);
        wait_drained();

        freq_plan[0] = mdt_pkg::FREQ_W'(mdt_pkg::MS_PER_SECOND);
        freq_plan[1] = '1;
        freq_plan[2] = mdt_pkg::FREQ_W'($urandom_range(1, 50000));
        freq_plan[3] = mdt_pkg::FREQ_W'(1);
        freq_plan[4] = mdt_pkg::FREQ_W'($urandom_range(500, 4000));
        for (int p = 0; p < 5; p++)
        begin
            set_frequency(freq_plan[p]);
            if (p == 1)
                rx_hold_cycles = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2)
                begin
                    tx_gap_max = (n < 40) ? 0 : 4;
                    rx_gap_max = (n < 40) ? 0 : 4;
                end
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                send_random_word();
            end
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("multi_slot_deadline_timer regression: pass");
        else
            $display("multi_slot_deadline_timer regression: fail");
        $finish;
    end

endmodule
